### rtl/dwpi_pkg.sv
// Shared types, constants and register map of the dual wheel PI speed controller.
package dwpi_pkg;

	localparam int CNT_W   = 16;
	localparam int CMD_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int DRV_W   = 13;
	localparam int INTEG_W = 40;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 2 * MUL_W;

	localparam logic signed [CMD_W-1:0] CMD_BOUND = 16'sd1000;

	// wheel speed scale: round(65536 * 100 * pi / 3724)
	localparam logic [MUL_W-1:0] SPEED_SCALE = 33'd5529;

	// reference = round((17*ang + 80*lin) * 65536 / 6000)
	//           = floor(((|k| << 12) + 187) / 375), signed by k
	localparam int REF_SHIFT = 38;
	localparam longint unsigned REF_DIV = 375;
	localparam longint unsigned REF_RECIP =
		((64'd1 << REF_SHIFT) + REF_DIV - 64'd1) / REF_DIV;
	localparam logic [MUL_W-1:0] REF_MULT = MUL_W'(REF_RECIP);
	localparam logic [11:0] REF_BIAS = 12'd187;

	localparam logic [GAIN_W-1:0] RST_KP_R = 16'd20608;
	localparam logic [GAIN_W-1:0] RST_KI_R = 16'd18237;
	localparam logic [GAIN_W-1:0] RST_RC_R = 16'd814;
	localparam logic [GAIN_W-1:0] RST_KP_L = 16'd15744;
	localparam logic [GAIN_W-1:0] RST_KI_L = 16'd17439;
	localparam logic [GAIN_W-1:0] RST_RC_L = 16'd1066;
	localparam logic [DRV_W-1:0]  RST_LIMIT = 13'd4198;
	localparam logic [DRV_W-1:0]  RST_DBAND = 13'd260;

	typedef enum logic [2:0] {
		REG_KP_R  = 3'd0,
		REG_KI_R  = 3'd1,
		REG_RC_R  = 3'd2,
		REG_KP_L  = 3'd3,
		REG_KI_L  = 3'd4,
		REG_RC_L  = 3'd5,
		REG_LIMIT = 3'd6,
		REG_DBAND = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp_r;
		logic [GAIN_W-1:0] ki_r;
		logic [GAIN_W-1:0] rc_r;
		logic [GAIN_W-1:0] kp_l;
		logic [GAIN_W-1:0] ki_l;
		logic [GAIN_W-1:0] rc_l;
		logic [DRV_W-1:0]  limit;
		logic [DRV_W-1:0]  dband;
	} cfg_t;

	typedef enum logic [3:0] {
		STP_NONE,
		STP_KIN,
		STP_REF,
		STP_SPD,
		STP_ERR,
		STP_INT,
		STP_KIHI,
		STP_KILO,
		STP_SUM,
		STP_CMP,
		STP_CORHI,
		STP_CORLO,
		STP_CORADD,
		STP_APPLY
	} step_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KIN,
		ST_REF,
		ST_SPD,
		ST_ERR,
		ST_INT,
		ST_KIHI,
		ST_KILO,
		ST_SUM,
		ST_CMP,
		ST_CORHI,
		ST_CORLO,
		ST_CORADD,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic  load;
		step_t step;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic clamp_any;
		logic out_free;
	} stat_t;

endpackage

### rtl/dual_wheel_pi_speed_controller.sv
// Top level of the dual wheel PI speed controller.
// One control tick per input transfer: raw encoder counts of both wheels plus a
// linear/angular command (adopted only when both parts lie strictly within
// +-1000). Each wheel runs a Q16.16 PI loop with back-calculation anti-windup
// and a symmetric clamp; the left wheel also has a deadband. Each wheel lane
// owns one 33x33 multiplier that is stepped through reference, speed, Kp, Ki
// and correction products in sequence. The later correction steps (low product,
// add, apply) run only when either wheel hits the drive limit. A tick ends
// when its result enters the free output register. A finished result waits
// in the output register, and the next tick is taken meanwhile. Registers
// reset to their default gains; there is no clearing pass after reset.
module dual_wheel_pi_speed_controller import dwpi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CNT_W-1:0]        enc_right,
	input  logic [CNT_W-1:0]        enc_left,
	input  logic signed [CMD_W-1:0] lin_cmd,
	input  logic signed [CMD_W-1:0] ang_cmd,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DRV_W-1:0]        pwm_right,
	output logic                    fwd_right,
	output logic [DRV_W-1:0]        pwm_left,
	output logic                    fwd_left,
	output logic                    cmd_taken
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	dwpi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dwpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	dwpi_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg       (cfg),
		.enc_right (enc_right),
		.enc_left  (enc_left),
		.lin_cmd   (lin_cmd),
		.ang_cmd   (ang_cmd),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.pwm_right (pwm_right),
		.fwd_right (fwd_right),
		.pwm_left  (pwm_left),
		.fwd_left  (fwd_left),
		.cmd_taken (cmd_taken)
	);

endmodule

### rtl/dwpi_regs.sv
// APB configuration registers: gains, reciprocals, drive limit and left deadband.
module dwpi_regs import dwpi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_r  <= RST_KP_R;
			cfg_q.ki_r  <= RST_KI_R;
			cfg_q.rc_r  <= RST_RC_R;
			cfg_q.kp_l  <= RST_KP_L;
			cfg_q.ki_l  <= RST_KI_L;
			cfg_q.rc_l  <= RST_RC_L;
			cfg_q.limit <= RST_LIMIT;
			cfg_q.dband <= RST_DBAND;
		end else if (wr_en) begin
			unique case (idx)
				REG_KP_R:  cfg_q.kp_r  <= pwdata[GAIN_W-1:0];
				REG_KI_R:  cfg_q.ki_r  <= pwdata[GAIN_W-1:0];
				REG_RC_R:  cfg_q.rc_r  <= pwdata[GAIN_W-1:0];
				REG_KP_L:  cfg_q.kp_l  <= pwdata[GAIN_W-1:0];
				REG_KI_L:  cfg_q.ki_l  <= pwdata[GAIN_W-1:0];
				REG_RC_L:  cfg_q.rc_l  <= pwdata[GAIN_W-1:0];
				REG_LIMIT: cfg_q.limit <= pwdata[DRV_W-1:0];
				REG_DBAND: cfg_q.dband <= pwdata[DRV_W-1:0];
				default:   cfg_q       <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KP_R:  prdata = DATA_W'(cfg_q.kp_r);
			REG_KI_R:  prdata = DATA_W'(cfg_q.ki_r);
			REG_RC_R:  prdata = DATA_W'(cfg_q.rc_r);
			REG_KP_L:  prdata = DATA_W'(cfg_q.kp_l);
			REG_KI_L:  prdata = DATA_W'(cfg_q.ki_l);
			REG_RC_L:  prdata = DATA_W'(cfg_q.rc_l);
			REG_LIMIT: prdata = DATA_W'(cfg_q.limit);
			REG_DBAND: prdata = DATA_W'(cfg_q.dband);
			default:   prdata = '0;
		endcase
	end

endmodule

### rtl/dwpi_wheel.sv
// One wheel lane: encoder delta, reference, PI with anti-windup, clamp, deadband.
module dwpi_wheel import dwpi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  step_t                   step,
	input  logic [CNT_W-1:0]        enc,
	input  logic signed [CMD_W-1:0] lin,
	input  logic signed [CMD_W:0]   ang,
	input  logic [GAIN_W-1:0]       kp,
	input  logic [GAIN_W-1:0]       ki,
	input  logic [GAIN_W-1:0]       recip,
	input  logic [DRV_W-1:0]        limit,
	input  logic [DRV_W-1:0]        dband,
	output logic                    clamped,
	output logic [DRV_W-1:0]        pwm,
	output logic                    fwd
);

	logic [CNT_W-1:0]           prev_q;
	logic signed [CNT_W-1:0]    delta_q;
	logic [16:0]                nabs_q;
	logic                       neg_q;
	logic signed [PROD_W-1:0]   p_q;
	logic signed [21:0]         ref_q;
	logic signed [31:0]         e_q;
	logic signed [INTEG_W-1:0]  integ_q;
	logic signed [57:0]         acc_q;
	logic                       pos_q;
	logic                       negc_q;
	logic [57:0]                ex_q;
	logic signed [37:0]         s_q;
	logic [39:0]                corr_q;

	logic signed [17:0]         k_c;
	logic signed [MUL_W-1:0]    ma;
	logic signed [MUL_W-1:0]    mb;
	logic                       mul_en;
	logic [20:0]                q_c;
	logic signed [57:0]         lim_c;
	logic signed [57:0]         nlim_c;
	logic                       pos_c;
	logic                       neg_c;
	logic [46:0]                exc;
	logic [36:0]                abs_c;
	logic                       db_hit;

	function automatic logic signed [INTEG_W-1:0] sat40(input logic signed [41:0] v);
		logic signed [INTEG_W-1:0] r;
		if (v[41:39] == 3'b000 || v[41:39] == 3'b111)
			r = v[INTEG_W-1:0];
		else if (v[41])
			r = {1'b1, {(INTEG_W-1){1'b0}}};
		else
			r = {1'b0, {(INTEG_W-1){1'b1}}};
		return r;
	endfunction

	// 17*ang + 80*lin by shifts
	assign k_c = (18'(ang) <<< 4) + 18'(ang) + (18'(lin) <<< 6) + (18'(lin) <<< 4);

	assign q_c    = p_q[REF_SHIFT+20:REF_SHIFT];
	assign lim_c  = $signed({21'b0, limit, 24'b0});
	assign nlim_c = -lim_c;
	assign pos_c  = acc_q >= lim_c;
	assign neg_c  = acc_q <= nlim_c;
	assign exc    = (|ex_q[57:47]) ? {47{1'b1}} : ex_q[46:0];

	always_comb begin
		mul_en = 1'b1;
		unique case (step)
			STP_REF: begin
				ma = $signed({4'b0, nabs_q, REF_BIAS});
				mb = $signed(REF_MULT);
			end
			STP_SPD: begin
				ma = MUL_W'(delta_q);
				mb = $signed(SPEED_SCALE);
			end
			STP_INT: begin
				ma = MUL_W'(e_q);
				mb = $signed({17'b0, kp});
			end
			STP_KIHI: begin
				ma = MUL_W'($signed(integ_q[39:20]));
				mb = $signed({17'b0, ki});
			end
			STP_KILO: begin
				ma = $signed({13'b0, integ_q[19:0]});
				mb = $signed({17'b0, ki});
			end
			STP_CORHI: begin
				ma = $signed({10'b0, exc[46:24]});
				mb = $signed({17'b0, recip});
			end
			STP_CORLO: begin
				ma = $signed({9'b0, exc[23:0]});
				mb = $signed({17'b0, recip});
			end
			default: begin
				ma     = '0;
				mb     = '0;
				mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
			pos_q   <= 1'b0;
			negc_q  <= 1'b0;
		end else begin
			if (load)
				prev_q <= enc;
			if (step == STP_INT)
				integ_q <= sat40(42'(integ_q) + 42'(e_q));
			else if (step == STP_APPLY && pos_q)
				integ_q <= sat40(42'(integ_q) - $signed({2'b0, corr_q}));
			else if (step == STP_APPLY && negc_q)
				integ_q <= sat40(42'(integ_q) + $signed({2'b0, corr_q}));
			if (step == STP_CMP) begin
				pos_q  <= pos_c;
				negc_q <= neg_c & ~pos_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			delta_q <= $signed(enc - prev_q);
		if (mul_en)
			p_q <= ma * mb;
		unique case (step)
			STP_KIN: begin
				neg_q  <= k_c[17];
				nabs_q <= k_c[17] ? 17'(-k_c) : 17'(k_c);
			end
			STP_SPD:    ref_q  <= neg_q ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
			STP_ERR:    e_q    <= 32'(ref_q) - $signed(p_q[31:0]);
			STP_KIHI:   acc_q  <= p_q[57:0];
			STP_KILO:   acc_q  <= acc_q + $signed({p_q[37:0], 20'b0});
			STP_SUM:    acc_q  <= acc_q + p_q[57:0];
			STP_CMP: begin
				ex_q <= pos_c ? 58'(acc_q - lim_c) : 58'(nlim_c - acc_q);
				s_q  <= pos_c ? lim_c[37:0] : (neg_c ? nlim_c[37:0] : acc_q[37:0]);
			end
			STP_CORLO:  corr_q <= p_q[39:0];
			STP_CORADD: corr_q <= corr_q + 40'(p_q[39:24]);
			default:    corr_q <= corr_q;
		endcase
	end

	assign clamped = pos_q | negc_q;
	assign abs_c   = s_q[37] ? 37'(-s_q) : 37'(s_q);
	assign db_hit  = abs_c < {dband, 24'b0};
	assign pwm     = db_hit ? '0 : abs_c[36:24];
	assign fwd     = db_hit | ~s_q[37];

endmodule

### rtl/dwpi_datapath.sv
// Datapath: command check and hold, two wheel lanes, output register.
module dwpi_datapath import dwpi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output stat_t                   stat,
	input  cfg_t                    cfg,
	input  logic [CNT_W-1:0]        enc_right,
	input  logic [CNT_W-1:0]        enc_left,
	input  logic signed [CMD_W-1:0] lin_cmd,
	input  logic signed [CMD_W-1:0] ang_cmd,
	input  logic                    out_stall,
	output logic                    out_valid,
	output logic [DRV_W-1:0]        pwm_right,
	output logic                    fwd_right,
	output logic [DRV_W-1:0]        pwm_left,
	output logic                    fwd_left,
	output logic                    cmd_taken
);

	logic signed [CMD_W-1:0] held_lin_q;
	logic signed [CMD_W-1:0] held_ang_q;
	logic                    taken_q;
	logic                    taken_c;
	logic signed [CMD_W:0]   ang_r;
	logic signed [CMD_W:0]   ang_l;
	logic                    clamp_r;
	logic                    clamp_l;
	logic [DRV_W-1:0]        pwm_r;
	logic [DRV_W-1:0]        pwm_l;
	logic                    fwd_r;
	logic                    fwd_l;
	logic                    out_valid_q;
	logic [DRV_W-1:0]        pwm_right_q;
	logic                    fwd_right_q;
	logic [DRV_W-1:0]        pwm_left_q;
	logic                    fwd_left_q;
	logic                    cmd_taken_q;

	assign taken_c = (lin_cmd > -CMD_BOUND) && (lin_cmd < CMD_BOUND) &&
	                 (ang_cmd > -CMD_BOUND) && (ang_cmd < CMD_BOUND);

	assign ang_r = 17'(held_ang_q);
	assign ang_l = -ang_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lin_q  <= '0;
			held_ang_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && taken_c) begin
				held_lin_q <= lin_cmd;
				held_ang_q <= ang_cmd;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			taken_q <= taken_c;
		if (cmd.out_load) begin
			pwm_right_q <= pwm_r;
			fwd_right_q <= fwd_r;
			pwm_left_q  <= pwm_l;
			fwd_left_q  <= fwd_l;
			cmd_taken_q <= taken_q;
		end
	end

	dwpi_wheel u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (cmd.load),
		.step    (cmd.step),
		.enc     (enc_right),
		.lin     (held_lin_q),
		.ang     (ang_r),
		.kp      (cfg.kp_r),
		.ki      (cfg.ki_r),
		.recip   (cfg.rc_r),
		.limit   (cfg.limit),
		.dband   ('0),
		.clamped (clamp_r),
		.pwm     (pwm_r),
		.fwd     (fwd_r)
	);

	dwpi_wheel u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (cmd.load),
		.step    (cmd.step),
		.enc     (enc_left),
		.lin     (held_lin_q),
		.ang     (ang_l),
		.kp      (cfg.kp_l),
		.ki      (cfg.ki_l),
		.recip   (cfg.rc_l),
		.limit   (cfg.limit),
		.dband   (cfg.dband),
		.clamped (clamp_l),
		.pwm     (pwm_l),
		.fwd     (fwd_l)
	);

	assign stat.clamp_any = clamp_r | clamp_l;
	assign stat.out_free  = ~out_valid_q | ~out_stall;

	assign out_valid = out_valid_q;
	assign pwm_right = pwm_right_q;
	assign fwd_right = fwd_right_q;
	assign pwm_left  = pwm_left_q;
	assign fwd_left  = fwd_left_q;
	assign cmd_taken = cmd_taken_q;

endmodule

### rtl/dwpi_ctrl.sv
// Controller: sequences the per-tick steps of both wheel lanes.
module dwpi_ctrl import dwpi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx     = state_q;
		in_stall     = 1'b1;
		cmd.load     = 1'b0;
		cmd.step     = STP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_KIN;
				end
			end
			ST_KIN: begin
				cmd.step = STP_KIN;
				state_nx = ST_REF;
			end
			ST_REF: begin
				cmd.step = STP_REF;
				state_nx = ST_SPD;
			end
			ST_SPD: begin
				cmd.step = STP_SPD;
				state_nx = ST_ERR;
			end
			ST_ERR: begin
				cmd.step = STP_ERR;
				state_nx = ST_INT;
			end
			ST_INT: begin
				cmd.step = STP_INT;
				state_nx = ST_KIHI;
			end
			ST_KIHI: begin
				cmd.step = STP_KIHI;
				state_nx = ST_KILO;
			end
			ST_KILO: begin
				cmd.step = STP_KILO;
				state_nx = ST_SUM;
			end
			ST_SUM: begin
				cmd.step = STP_SUM;
				state_nx = ST_CMP;
			end
			ST_CMP: begin
				cmd.step = STP_CMP;
				state_nx = ST_CORHI;
			end
			ST_CORHI: begin
				cmd.step = STP_CORHI;
				state_nx = stat.clamp_any ? ST_CORLO : ST_DONE;
			end
			ST_CORLO: begin
				cmd.step = STP_CORLO;
				state_nx = ST_CORADD;
			end
			ST_CORADD: begin
				cmd.step = STP_CORADD;
				state_nx = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.step = STP_APPLY;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule
